// ===== hw/rtl/trv_pkg.sv =====
`default_nettype none

package trv_pkg;

   localparam int unsigned MAX_DEPTH = 255;

   localparam logic [1:0] STATUS_DONE     = 2'd0;
   localparam logic [1:0] STATUS_TRUNC    = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   localparam logic [7:0] MAX_RECORDS_RESET = 8'd8;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       buffer_end;
   } trv_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  record_index;
      logic [7:0]  deepest_level;
      logic [31:0] text_chars;
      logic        no_more;
   } trv_rsp_type;

   typedef struct packed {
      logic        valid;
      trv_rsp_type rsp;
   } trv_result_type;

endpackage

`default_nettype wire

// ===== hw/rtl/trv_parser.sv =====
`default_nettype none

module trv_parser (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    accept,
   input  wire trv_pkg::trv_req_type    req,
   input  wire logic                    csr_wr_en,
   input  wire logic [7:0]              csr_wr_data,
   output trv_pkg::trv_result_type      result
);
   import trv_pkg::*;

   typedef enum logic [1:0] {
      PH_ROOT  = 2'd0,
      PH_NAME  = 2'd1,
      PH_AFTER = 2'd2
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  name_left_ff, name_left_in;
   logic [7:0]  cur_level_ff, cur_level_in;
   logic [7:0]  max_level_ff, max_level_in;
   logic [31:0] char_total_ff, char_total_in;
   logic [7:0]  records_done_ff, records_done_in;
   logic        stopped_ff, stopped_in;
   logic [7:0]  max_records_ff;

   logic        is_root;
   logic [8:0]  next_level;
   logic [7:0]  add_level;
   logic [31:0] add_base;
   logic [32:0] add_sum;
   logic [31:0] sat_total;
   logic [8:0]  rec_count;
   logic        rec_limit;

   assign is_root    = (phase_ff != PH_NAME) && (phase_ff != PH_AFTER);
   assign next_level = {1'b0, cur_level_ff} + 9'd1;
   assign add_level  = is_root ? 8'd0 : next_level[7:0];
   assign add_base   = is_root ? 32'd0 : char_total_ff;
   assign add_sum    = {1'b0, add_base} + {25'd0, add_level} + {25'd0, req.data_byte} + 33'd2;
   assign sat_total  = add_sum[32] ? 32'hFFFF_FFFF : add_sum[31:0];
   assign rec_count  = {1'b0, records_done_ff} + 9'd1;
   assign rec_limit  = rec_count >= {1'b0, max_records_ff};

   always_comb begin
      logic done_rec;
      logic overflow;
      phase_in        = phase_ff;
      name_left_in    = name_left_ff;
      cur_level_in    = cur_level_ff;
      max_level_in    = max_level_ff;
      char_total_in   = char_total_ff;
      records_done_in = records_done_ff;
      stopped_in      = stopped_ff;
      result          = '0;
      done_rec        = 1'b0;
      overflow        = 1'b0;

      if (accept && !stopped_ff) begin
         unique case (phase_ff)
            PH_NAME: begin
               name_left_in = name_left_ff - 8'd1;
               if (name_left_ff == 8'd1) begin
                  phase_in = PH_AFTER;
               end
            end
            PH_AFTER: begin
               if (req.data_byte != 8'd0) begin
                  if (next_level > 9'(MAX_DEPTH)) begin
                     overflow = 1'b1;
                  end else begin
                     cur_level_in  = next_level[7:0];
                     char_total_in = sat_total;
                     if (next_level[7:0] > max_level_ff) begin
                        max_level_in = next_level[7:0];
                     end
                     name_left_in = req.data_byte;
                     phase_in     = PH_NAME;
                  end
               end else if (cur_level_ff == 8'd0) begin
                  done_rec = 1'b1;
               end else begin
                  cur_level_in = cur_level_ff - 8'd1;
               end
            end
            default: begin
               cur_level_in  = 8'd0;
               max_level_in  = 8'd0;
               char_total_in = sat_total;
               name_left_in  = req.data_byte;
               phase_in      = (req.data_byte != 8'd0) ? PH_NAME : PH_AFTER;
            end
         endcase

         result.rsp.record_index  = records_done_ff;
         result.rsp.deepest_level = max_level_in;
         result.rsp.text_chars    = char_total_in;

         if (overflow) begin
            result.valid       = 1'b1;
            result.rsp.status  = STATUS_OVERFLOW;
            result.rsp.no_more = 1'b1;
            stopped_in         = 1'b1;
         end else if (done_rec) begin
            result.valid       = 1'b1;
            result.rsp.status  = STATUS_DONE;
            result.rsp.no_more = rec_limit || req.buffer_end;
            phase_in           = PH_ROOT;
            records_done_in    = rec_count[7:0];
            if (rec_limit) begin
               stopped_in = 1'b1;
            end
         end else if (req.buffer_end) begin
            result.valid       = 1'b1;
            result.rsp.status  = STATUS_TRUNC;
            result.rsp.no_more = 1'b1;
         end
      end

      // buffer end restarts everything but the register
      if (accept && req.buffer_end) begin
         phase_in        = PH_ROOT;
         name_left_in    = 8'd0;
         cur_level_in    = 8'd0;
         max_level_in    = 8'd0;
         char_total_in   = 32'd0;
         records_done_in = 8'd0;
         stopped_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_ROOT;
         name_left_ff    <= 8'd0;
         cur_level_ff    <= 8'd0;
         max_level_ff    <= 8'd0;
         char_total_ff   <= 32'd0;
         records_done_ff <= 8'd0;
         stopped_ff      <= 1'b0;
         max_records_ff  <= MAX_RECORDS_RESET;
      end else begin
         phase_ff        <= phase_in;
         name_left_ff    <= name_left_in;
         cur_level_ff    <= cur_level_in;
         max_level_ff    <= max_level_in;
         char_total_ff   <= char_total_in;
         records_done_ff <= records_done_in;
         stopped_ff      <= stopped_in;
         if (csr_wr_en) begin
            max_records_ff <= csr_wr_data;
         end
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/tree_record_validator_top.sv =====
`default_nettype none

// Channel   Direction  Handshake          Payload
// req_      in         req_valid/stall    trv_req_type: data_byte, buffer_end
// rsp_      out        rsp_valid/stall    trv_rsp_type: status, record_index,
//                                           deepest_level, text_chars, no_more
// csr_      in         csr_wr_en          csr_wr_data: max_records
//
// One request per cycle while req_stall is low; results are registered onto rsp_.
// The parse state updates in the same cycle the byte is taken.
// Output register plus one skid entry: req_stall rises only when both are full.
// Sync reset clears parse state and both valid flags, and sets max_records to 8.

module tree_record_validator_top (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire trv_pkg::trv_req_type req_data,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output trv_pkg::trv_rsp_type rsp_data,
   input  wire logic          csr_wr_en,
   input  wire logic [7:0]    csr_wr_data
);
   import trv_pkg::*;

   logic           accept;
   logic           take;
   trv_result_type result;

   logic           out_valid_ff, out_valid_in;
   trv_rsp_type    out_data_ff, out_data_in;
   logic           skid_valid_ff, skid_valid_in;
   trv_rsp_type    skid_data_ff, skid_data_in;

   assign accept    = req_valid && !skid_valid_ff;
   assign take      = out_valid_ff && !rsp_stall;
   assign req_stall = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   trv_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req         (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .result      (result)
   );

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         // advance the skid entry once the output drains
         if (take) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!out_valid_ff || take) begin
         out_valid_in = result.valid;
         out_data_in  = result.rsp;
      end else if (result.valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = result.rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

`default_nettype wire

// ===== dv/tree_record_validator_top_tb.sv =====
`timescale 1ns / 100ps

module tree_record_validator_top_tb;
   import trv_pkg::*;

   localparam int unsigned RANDOM_ITEMS   = 600;
   localparam int unsigned RANDOM_PHASES  = 6;
   localparam int unsigned HOLD_CYCLES    = 200;
   localparam int unsigned SETTLE_CYCLES  = 4;
   localparam int unsigned TAIL_CYCLES    = 8;
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned FLOOD_RECORDS  = 64;

   typedef enum logic [1:0] {
      EXPECT_ROOT = 2'd0,
      IN_NAME     = 2'd1,
      AFTER_NAME  = 2'd2
   } parse_phase_e;

   typedef enum int unsigned {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_SOLID
   } stall_mode_e;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   trv_req_type req_data    = '0;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   trv_rsp_type rsp_data;
   logic        csr_wr_en   = 1'b0;
   logic [7:0]  csr_wr_data = '0;

   wire req_fire = req_valid && !req_stall;
   wire rsp_fire = rsp_valid && !rsp_stall;

   tree_record_validator_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   class record_scoreboard;
      trv_rsp_type  pending_reports[$];
      logic [7:0]   record_limit;
      parse_phase_e parse_at;
      logic [7:0]   name_left;
      logic [7:0]   cur_level;
      logic [7:0]   deepest;
      logic [31:0]  char_total;
      logic [7:0]   records_done;
      logic         stopped;
      int unsigned  errors;
      int unsigned  parsed;
      int unsigned  ignored;
      int unsigned  checked;

      function new();
         record_limit = MAX_RECORDS_RESET;
         errors = 0;
         parsed = 0;
         ignored = 0;
         checked = 0;
         clear_buffer();
      endfunction

      function void clear_buffer();
         parse_at = EXPECT_ROOT;
         name_left = '0;
         cur_level = '0;
         deepest = '0;
         char_total = '0;
         records_done = '0;
         stopped = 1'b0;
      endfunction

      function void set_limit(logic [7:0] value);
         record_limit = value;
      endfunction

      function int unsigned outstanding();
         return pending_reports.size();
      endfunction

      function void count_node(logic [7:0] level, logic [7:0] len);
         logic [32:0] sum;
         sum = {1'b0, char_total} + 33'(level) + 33'(len) + 33'd2;
         char_total = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
         if (level > deepest) begin
            deepest = level;
         end
      endfunction

      function void push_report(logic [1:0] status, logic last_one);
         trv_rsp_type r;
         r.status = status;
         r.record_index = records_done;
         r.deepest_level = deepest;
         r.text_chars = char_total;
         r.no_more = last_one;
         pending_reports.push_back(r);
      endfunction

      function void take_byte(trv_req_type r);
         logic [8:0] next_level;
         logic [8:0] count;
         logic       closed;
         logic       at_limit;
         closed = 1'b0;
         if (stopped) begin
            ignored++;
            if (r.buffer_end) begin
               clear_buffer();
            end
            return;
         end
         parsed++;
         case (parse_at)
            IN_NAME: begin
               name_left = name_left - 8'd1;
               if (name_left == 8'd0) begin
                  parse_at = AFTER_NAME;
               end
            end
            AFTER_NAME: begin
               if (r.data_byte != 8'd0) begin
                  next_level = {1'b0, cur_level} + 9'd1;
                  if (next_level > MAX_DEPTH) begin
                     // overflowing node is not counted; beats a buffer end
                     push_report(STATUS_OVERFLOW, 1'b1);
                     if (r.buffer_end) begin
                        clear_buffer();
                     end else begin
                        stopped = 1'b1;
                     end
                     return;
                  end
                  cur_level = next_level[7:0];
                  count_node(cur_level, r.data_byte);
                  name_left = r.data_byte;
                  parse_at = IN_NAME;
               end else if (cur_level == 8'd0) begin
                  closed = 1'b1;
               end else begin
                  cur_level = cur_level - 8'd1;
               end
            end
            default: begin
               cur_level = '0;
               deepest = '0;
               char_total = '0;
               count_node(8'd0, r.data_byte);
               name_left = r.data_byte;
               parse_at = (r.data_byte != 8'd0) ? IN_NAME : AFTER_NAME;
            end
         endcase
         if (closed) begin
            count = {1'b0, records_done} + 9'd1;
            at_limit = (count >= {1'b0, record_limit});
            push_report(STATUS_DONE, at_limit || r.buffer_end);
            parse_at = EXPECT_ROOT;
            records_done = count[7:0];
            if (at_limit) begin
               stopped = 1'b1;
            end
         end else if (r.buffer_end) begin
            push_report(STATUS_TRUNC, 1'b1);
         end
         if (r.buffer_end) begin
            clear_buffer();
         end
      endfunction

      function void compare_field(string field, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            errors++;
         end
      endfunction

      function void check_report(trv_rsp_type got);
         trv_rsp_type want;
         if (pending_reports.size() == 0) begin
            $error("result with nothing expected: status %0d record_index %0d",
                   got.status, got.record_index);
            errors++;
            return;
         end
         want = pending_reports.pop_front();
         checked++;
         compare_field("status", 32'(want.status), 32'(got.status));
         compare_field("record_index", 32'(want.record_index), 32'(got.record_index));
         compare_field("deepest_level", 32'(want.deepest_level), 32'(got.deepest_level));
         compare_field("text_chars", want.text_chars, got.text_chars);
         compare_field("no_more", 32'(want.no_more), 32'(got.no_more));
      endfunction
   endclass

   record_scoreboard sb = new();

   trv_req_type byte_stream[$];
   int unsigned burst_left;
   int unsigned holds_asked = 0;
   int unsigned holds_done  = 0;
   int unsigned quiet_cycles = 0;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_fire) begin
            sb.take_byte(req_data);
         end
         if (rsp_fire) begin
            sb.check_report(rsp_data);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || req_fire || rsp_fire) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("tree_record_validator_top_tb: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // receiver: random stall runs, plus a long hold whenever one is asked for
   initial begin : rsp_pattern
      int unsigned run_len;
      stall_mode_e mode;
      @(posedge clock);
      forever begin
         if (holds_asked != holds_done) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            holds_done++;
         end else begin
            run_len = $urandom_range(4, 40);
            mode = stall_mode_e'($urandom_range(0, 3));
            repeat (run_len) begin
               case (mode)
                  STALL_NONE:  rsp_stall <= 1'b0;
                  STALL_LIGHT: rsp_stall <= ($urandom_range(0, 99) < 25);
                  STALL_HEAVY: rsp_stall <= ($urandom_range(0, 99) < 75);
                  default:     rsp_stall <= 1'b1;
               endcase
               @(posedge clock);
            end
         end
      end
   end

   function automatic int unsigned pick_burst();
      if ($urandom_range(0, 99) < 20) begin
         return $urandom_range(100, 300);
      end
      return $urandom_range(1, 30);
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 80) begin
         return $urandom_range(1, 6);
      end else if (r < 95) begin
         return $urandom_range(7, 30);
      end
      return $urandom_range(40, 80);
   endfunction

   function automatic void queue_byte(logic [7:0] b, logic last_one);
      trv_req_type r;
      r.data_byte = b;
      r.buffer_end = last_one;
      byte_stream.push_back(r);
   endfunction

   function automatic void queue_name(int unsigned len);
      repeat (len) queue_byte(8'($urandom_range(0, 255)), 1'b0);
   endfunction

   function automatic int unsigned pick_len(bit is_root);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (is_root && r < 20) begin
         return 0;
      end else if (r < 70) begin
         return $urandom_range(1, 3);
      end else if (r < 96) begin
         return $urandom_range(4, 16);
      end
      return $urandom_range(200, 255);
   endfunction

   function automatic void build_node(int unsigned level);
      int unsigned len;
      int unsigned kids;
      len = pick_len(level == 0);
      queue_byte(8'(len), 1'b0);
      queue_name(len);
      kids = (level < 4) ? $urandom_range(0, 2) : 0;
      repeat (kids) build_node(level + 1);
      queue_byte(8'h00, 1'b0);
   endfunction

   // root plus MAX_DEPTH nested children, then one child too many
   function automatic void build_deep_chain(logic end_on_overflow);
      int unsigned len;
      len = $urandom_range(0, 2);
      queue_byte(8'(len), 1'b0);
      queue_name(len);
      repeat (MAX_DEPTH) begin
         queue_byte(8'h01, 1'b0);
         queue_name(1);
      end
      queue_byte(8'($urandom_range(1, 255)), end_on_overflow);
   endfunction

   function automatic void mark_buffer_end();
      byte_stream[byte_stream.size() - 1].buffer_end = 1'b1;
   endfunction

   function automatic void build_buffer();
      int unsigned kind;
      kind = $urandom_range(0, 99);
      if (kind < 12) begin
         repeat ($urandom_range(1, 10)) queue_byte(8'($urandom_range(0, 255)),
                                                    1'($urandom_range(0, 1)));
      end else begin
         repeat ($urandom_range(1, 4)) build_node(0);
         if (kind < 30) begin
            // cut the tail so the buffer ends mid-record
            repeat ($urandom_range(1, 6)) begin
               if (byte_stream.size() > 1) begin
                  void'(byte_stream.pop_back());
               end
            end
         end else if (kind < 42) begin
            queue_name($urandom_range(1, 5));
         end
      end
      mark_buffer_end();
   endfunction

   // call just after posedge clock; leaves req_valid high unless a gap closed the burst
   task automatic send_stream();
      trv_req_type item;
      while (byte_stream.size() > 0) begin
         item = byte_stream.pop_front();
         req_valid <= 1'b1;
         req_data <= item;
         @(posedge clock);
         while (req_stall) @(posedge clock);
         burst_left--;
         if (burst_left == 0) begin
            req_valid <= 1'b0;
            repeat (pick_gap()) @(posedge clock);
            burst_left = pick_burst();
         end
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(logic [7:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.set_limit(value);
      @(posedge clock);
   endtask

   initial begin : stimulus
      int unsigned goal;
      logic [7:0]  phase_limits [RANDOM_PHASES];
      logic [7:0]  limit;
      phase_limits = '{8'd3, 8'd255, 8'd1, 8'd0, 8'd2, 8'd255};
      burst_left = pick_burst();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset limit of 8: empty root, named tree ended on its closing byte
      queue_byte(8'h00, 1'b0);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'h02, 1'b0);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'h01, 1'b0);
      queue_byte(8'h7F, 1'b0);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'h00, 1'b1);
      // end inside a name, then end on a lone root byte
      queue_byte(8'h03, 1'b0);
      queue_byte(8'hAA, 1'b0);
      queue_byte(8'h55, 1'b1);
      queue_byte(8'h00, 1'b1);
      send_stream();
      settle();

      // limit of one: bytes after the first record are dropped until the end
      write_limit(8'd1);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'h05, 1'b0);
      queue_byte(8'h00, 1'b1);
      queue_byte(8'h01, 1'b0);
      queue_byte(8'h80, 1'b0);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'hFF, 1'b1);
      send_stream();
      settle();

      // limit of zero, depth overflow with and without a buffer end on it
      write_limit(8'd0);
      build_deep_chain(1'b1);
      build_deep_chain(1'b0);
      queue_name(3);
      queue_byte(8'h00, 1'b1);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'h00, 1'b1);
      send_stream();
      settle();

      // hold the receiver while tiny records flood in; stop at the record limit
      write_limit(8'(FLOOD_RECORDS));
      holds_asked++;
      repeat (FLOOD_RECORDS + 1) begin
         queue_byte(8'h00, 1'b0);
         queue_byte(8'h00, 1'b0);
      end
      mark_buffer_end();
      burst_left = 100000;
      send_stream();
      burst_left = pick_burst();
      settle();

      for (int i = 0; i < RANDOM_PHASES; i++) begin
         limit = (i == 3) ? 8'($urandom_range(4, 254)) : phase_limits[i];
         write_limit(limit);
         goal = sb.parsed + sb.ignored + RANDOM_ITEMS / RANDOM_PHASES;
         while (sb.parsed + sb.ignored < goal) begin
            build_buffer();
            send_stream();
         end
         settle();
      end

      while (sb.outstanding() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Run covered %0d parsed bytes, %0d dropped after a stop, %0d results checked;",
               sb.parsed, sb.ignored, sb.checked);
      $display("record limits 8, 0, 1, 2, 3, 64, 255 and random, full depth overflow, long hold.");
      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("tree_record_validator_top_tb: PASS");
      end else begin
         $display("tree_record_validator_top_tb: FAIL");
      end
      $finish;
   end

endmodule
